// ----- sv/lsr_pkg.sv -----
// Shared definitions for the line span rasterizer.
// Holds operation codes and default widths; no dependencies.
`default_nettype none

package lsr_pkg;

  localparam int COORD_BITS_DEFAULT = 12;
  localparam int COLOR_BITS         = 16;

  typedef enum logic {
    OP_LOAD = 1'b0,
    OP_STEP = 1'b1
  } op_t;

endpackage

`default_nettype wire

// ----- sv/line_span_rasterizer.sv -----
// Line span rasterizer top level: walker plus result register.
// Depends on lsr_pkg, lsr_walker and lsr_out_reg.
`default_nettype none

// Takes one transfer per clock. A load (operation 0) stores a line and gives no
// result. Each step (operation 1) gives one result in the next cycle: a single
// span for a horizontal or vertical line, otherwise the end pixel followed by
// one Bresenham pixel per step from the start, with last set on the final one.
// The walk is one add and compare per step, so a line of N pixels drains in N
// steps at one per clock. A step while idle gives nothing; a load drops any
// line in progress. Input stalls only while a result waits on a stalled output.

module line_span_rasterizer
  import lsr_pkg::*;
#(
  parameter int COORD_BITS = COORD_BITS_DEFAULT
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  in_valid,
  output logic                       in_stall,
  input  wire logic                  operation,
  input  wire logic [COORD_BITS-1:0] start_x,
  input  wire logic [COORD_BITS-1:0] start_y,
  input  wire logic [COORD_BITS-1:0] end_x,
  input  wire logic [COORD_BITS-1:0] end_y,
  input  wire logic [COLOR_BITS-1:0] pen_color,
  output logic                       out_valid,
  input  wire logic                  out_stall,
  output logic [COORD_BITS-1:0]      pixel_x,
  output logic [COORD_BITS-1:0]      pixel_y,
  output logic [COORD_BITS:0]        run_width,
  output logic [COORD_BITS:0]        run_height,
  output logic [COLOR_BITS-1:0]      out_color,
  output logic                       last
);

  logic                  accept;
  logic                  res_valid;
  logic [COORD_BITS-1:0] res_x, res_y;
  logic [COORD_BITS:0]   res_width, res_height;
  logic [COLOR_BITS-1:0] res_color;
  logic                  res_last;

  assign accept = in_valid && !in_stall;

  lsr_walker #(
    .COORD_BITS(COORD_BITS)
  ) u_walker (
    .clk       (clk),
    .rst       (rst),
    .accept    (accept),
    .operation (operation),
    .start_x   (start_x),
    .start_y   (start_y),
    .end_x     (end_x),
    .end_y     (end_y),
    .pen_color (pen_color),
    .res_valid (res_valid),
    .res_x     (res_x),
    .res_y     (res_y),
    .res_width (res_width),
    .res_height(res_height),
    .res_color (res_color),
    .res_last  (res_last)
  );

  lsr_out_reg #(
    .COORD_BITS(COORD_BITS)
  ) u_out_reg (
    .clk       (clk),
    .rst       (rst),
    .load      (res_valid),
    .res_x     (res_x),
    .res_y     (res_y),
    .res_width (res_width),
    .res_height(res_height),
    .res_color (res_color),
    .res_last  (res_last),
    .out_stall (out_stall),
    .out_valid (out_valid),
    .busy_out  (in_stall),
    .pixel_x   (pixel_x),
    .pixel_y   (pixel_y),
    .run_width (run_width),
    .run_height(run_height),
    .out_color (out_color),
    .last      (last)
  );

endmodule

`default_nettype wire

// ----- sv/lsr_walker.sv -----
// Line state and Bresenham step logic: one transfer in, at most one result out.
// Uses lsr_pkg for operation codes and color width.
`default_nettype none

module lsr_walker
  import lsr_pkg::*;
#(
  parameter int COORD_BITS = COORD_BITS_DEFAULT
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  accept,
  input  wire logic                  operation,
  input  wire logic [COORD_BITS-1:0] start_x,
  input  wire logic [COORD_BITS-1:0] start_y,
  input  wire logic [COORD_BITS-1:0] end_x,
  input  wire logic [COORD_BITS-1:0] end_y,
  input  wire logic [COLOR_BITS-1:0] pen_color,
  output logic                       res_valid,
  output logic [COORD_BITS-1:0]      res_x,
  output logic [COORD_BITS-1:0]      res_y,
  output logic [COORD_BITS:0]        res_width,
  output logic [COORD_BITS:0]        res_height,
  output logic [COLOR_BITS-1:0]      res_color,
  output logic                       res_last
);

  localparam int ERR_W = COORD_BITS + 2;
  localparam int RUN_W = COORD_BITS + 1;

  logic                    busy, busy_next;
  logic                    axis_span_pending, axis_span_pending_next;
  logic                    end_pixel_pending, end_pixel_pending_next;
  logic [COORD_BITS-1:0]   walk_x, walk_x_next;
  logic [COORD_BITS-1:0]   walk_y, walk_y_next;
  logic [COORD_BITS-1:0]   target_x, target_x_next;
  logic [COORD_BITS-1:0]   target_y, target_y_next;
  logic [COORD_BITS-1:0]   delta_x, delta_x_next;
  logic [COORD_BITS-1:0]   delta_y, delta_y_next;
  logic                    step_x_negative, step_x_negative_next;
  logic                    step_y_negative, step_y_negative_next;
  logic signed [ERR_W-1:0] error_term, error_term_next;
  logic [COLOR_BITS-1:0]   line_color, line_color_next;
  logic [RUN_W-1:0]        span_w, span_w_next;
  logic [RUN_W-1:0]        span_h, span_h_next;

  logic [COORD_BITS-1:0]   lo_x, hi_x, lo_y, hi_y;
  logic [COORD_BITS-1:0]   dx_load, dy_load;
  logic                    sxn_load, syn_load;
  logic signed [ERR_W-1:0] e2, dx_s, dy_s;
  logic                    move_x, move_y;
  logic [COORD_BITS-1:0]   nx, ny;

  always_comb begin
    lo_x     = (start_x < end_x) ? start_x : end_x;
    hi_x     = (start_x < end_x) ? end_x : start_x;
    lo_y     = (start_y < end_y) ? start_y : end_y;
    hi_y     = (start_y < end_y) ? end_y : start_y;
    sxn_load = !(start_x < end_x);
    syn_load = !(start_y < end_y);
    dx_load  = sxn_load ? start_x - end_x : end_x - start_x;
    dy_load  = syn_load ? start_y - end_y : end_y - start_y;

    dx_s   = $signed({2'b00, delta_x});
    dy_s   = $signed({2'b00, delta_y});
    e2     = error_term <<< 1;
    move_x = e2 > -dy_s;
    move_y = e2 < dx_s;
    nx     = move_x ? (step_x_negative ? walk_x - 1'b1 : walk_x + 1'b1) : walk_x;
    ny     = move_y ? (step_y_negative ? walk_y - 1'b1 : walk_y + 1'b1) : walk_y;

    busy_next              = busy;
    axis_span_pending_next = axis_span_pending;
    end_pixel_pending_next = end_pixel_pending;
    walk_x_next            = walk_x;
    walk_y_next            = walk_y;
    target_x_next          = target_x;
    target_y_next          = target_y;
    delta_x_next           = delta_x;
    delta_y_next           = delta_y;
    step_x_negative_next   = step_x_negative;
    step_y_negative_next   = step_y_negative;
    error_term_next        = error_term;
    line_color_next        = line_color;
    span_w_next            = span_w;
    span_h_next            = span_h;

    res_valid  = 1'b0;
    res_x      = walk_x;
    res_y      = walk_y;
    res_width  = RUN_W'(1);
    res_height = RUN_W'(1);
    res_color  = line_color;
    res_last   = 1'b0;

    if (accept) begin
      case (op_t'(operation))
        OP_LOAD: begin
          line_color_next        = pen_color;
          busy_next              = 1'b1;
          axis_span_pending_next = 1'b0;
          end_pixel_pending_next = 1'b0;
          if (start_x == end_x || start_y == end_y) begin
            axis_span_pending_next = 1'b1;
            walk_x_next            = lo_x;
            walk_y_next            = lo_y;
            span_w_next            = {1'b0, hi_x} - {1'b0, lo_x} + RUN_W'(1);
            span_h_next            = {1'b0, hi_y} - {1'b0, lo_y} + RUN_W'(1);
          end else begin
            end_pixel_pending_next = 1'b1;
            walk_x_next            = start_x;
            walk_y_next            = start_y;
            target_x_next          = end_x;
            target_y_next          = end_y;
            step_x_negative_next   = sxn_load;
            step_y_negative_next   = syn_load;
            delta_x_next           = dx_load;
            delta_y_next           = dy_load;
            error_term_next        = $signed({2'b00, dx_load}) - $signed({2'b00, dy_load});
          end
        end
        OP_STEP: begin
          if (busy) begin
            res_valid = 1'b1;
            if (axis_span_pending) begin
              res_width              = span_w;
              res_height             = span_h;
              res_last               = 1'b1;
              axis_span_pending_next = 1'b0;
              busy_next              = 1'b0;
            end else if (end_pixel_pending) begin
              res_x                  = target_x;
              res_y                  = target_y;
              end_pixel_pending_next = 1'b0;
            end else begin
              error_term_next = error_term - (move_x ? dy_s : '0) + (move_y ? dx_s : '0);
              walk_x_next     = nx;
              walk_y_next     = ny;
              res_last        = (nx == target_x) && (ny == target_y);
              if (res_last) begin
                busy_next = 1'b0;
              end
            end
          end
        end
        default: begin
          res_valid = 1'b0;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy              <= 1'b0;
      axis_span_pending <= 1'b0;
      end_pixel_pending <= 1'b0;
    end else begin
      busy              <= busy_next;
      axis_span_pending <= axis_span_pending_next;
      end_pixel_pending <= end_pixel_pending_next;
    end
  end

  always_ff @(posedge clk) begin
    walk_x          <= walk_x_next;
    walk_y          <= walk_y_next;
    target_x        <= target_x_next;
    target_y        <= target_y_next;
    delta_x         <= delta_x_next;
    delta_y         <= delta_y_next;
    step_x_negative <= step_x_negative_next;
    step_y_negative <= step_y_negative_next;
    error_term      <= error_term_next;
    line_color      <= line_color_next;
    span_w          <= span_w_next;
    span_h          <= span_h_next;
  end

endmodule

`default_nettype wire

// ----- sv/lsr_out_reg.sv -----
// Result register between the walker and the output channel.
// Uses lsr_pkg for color width.
`default_nettype none

module lsr_out_reg
  import lsr_pkg::*;
#(
  parameter int COORD_BITS = COORD_BITS_DEFAULT
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  load,
  input  wire logic [COORD_BITS-1:0] res_x,
  input  wire logic [COORD_BITS-1:0] res_y,
  input  wire logic [COORD_BITS:0]   res_width,
  input  wire logic [COORD_BITS:0]   res_height,
  input  wire logic [COLOR_BITS-1:0] res_color,
  input  wire logic                  res_last,
  input  wire logic                  out_stall,
  output logic                       out_valid,
  output logic                       busy_out,
  output logic [COORD_BITS-1:0]      pixel_x,
  output logic [COORD_BITS-1:0]      pixel_y,
  output logic [COORD_BITS:0]        run_width,
  output logic [COORD_BITS:0]        run_height,
  output logic [COLOR_BITS-1:0]      out_color,
  output logic                       last
);

  assign busy_out = out_valid && out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      pixel_x    <= res_x;
      pixel_y    <= res_y;
      run_width  <= res_width;
      run_height <= res_height;
      out_color  <= res_color;
      last       <= res_last;
    end
  end

endmodule

`default_nettype wire

// ----- sim/tb_top.sv -----
// Self-checking bench for line_span_rasterizer: drives line loads and steps,
// predicts every span or pixel write and compares the outputs field by field.
// Depends on lsr_pkg and line_span_rasterizer.
`timescale 1ns / 1ps

module tb_top;
  import lsr_pkg::*;

  localparam int CB = COORD_BITS_DEFAULT;
  localparam int MAX_COORD = (1 << CB) - 1;
  localparam int RANDOM_ITEMS = 1400;
  localparam int QUIET_LIMIT = 4000;

  typedef struct packed {
    op_t                   op;
    logic [CB-1:0]         sx;
    logic [CB-1:0]         sy;
    logic [CB-1:0]         ex;
    logic [CB-1:0]         ey;
    logic [COLOR_BITS-1:0] color;
  } line_cmd_t;

  typedef struct packed {
    logic [CB-1:0]         x;
    logic [CB-1:0]         y;
    logic [CB:0]           w;
    logic [CB:0]           h;
    logic [COLOR_BITS-1:0] color;
    logic                  last;
  } pixel_write_t;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  in_valid = 1'b0;
  logic                  in_stall;
  logic                  operation = OP_STEP;
  logic [CB-1:0]         start_x = '0;
  logic [CB-1:0]         start_y = '0;
  logic [CB-1:0]         end_x = '0;
  logic [CB-1:0]         end_y = '0;
  logic [COLOR_BITS-1:0] pen_color = '0;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  logic [CB-1:0]         pixel_x;
  logic [CB-1:0]         pixel_y;
  logic [CB:0]           run_width;
  logic [CB:0]           run_height;
  logic [COLOR_BITS-1:0] out_color;
  logic                  last;

  line_cmd_t    line_cmds[$];
  pixel_write_t expected_writes[$];
  line_cmd_t    next_cmd;
  pixel_write_t got_write;
  pixel_write_t want_write;
  int           cmds_sent = 0;
  int           mismatches = 0;
  int           quiet_cycles = 0;

  // predictor state
  logic                  ln_busy = 1'b0;
  logic                  span_due = 1'b0;
  logic                  endpt_due = 1'b0;
  logic [CB-1:0]         cur_x = '0;
  logic [CB-1:0]         cur_y = '0;
  logic [CB-1:0]         dest_x = '0;
  logic [CB-1:0]         dest_y = '0;
  int                    dist_x = 0;
  int                    dist_y = 0;
  logic                  neg_x = 1'b0;
  logic                  neg_y = 1'b0;
  int                    err_acc = 0;
  logic [COLOR_BITS-1:0] ln_color = '0;
  logic [CB:0]           span_w = '0;
  logic [CB:0]           span_h = '0;

  line_span_rasterizer #(
    .COORD_BITS(CB)
  ) i_dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .operation (operation),
    .start_x   (start_x),
    .start_y   (start_y),
    .end_x     (end_x),
    .end_y     (end_y),
    .pen_color (pen_color),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .pixel_x   (pixel_x),
    .pixel_y   (pixel_y),
    .run_width (run_width),
    .run_height(run_height),
    .out_color (out_color),
    .last      (last)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  function automatic int send_idle_pct();
    case ((cmds_sent / 64) % 4)
      1: return 81;
      3: return 38;
      default: return 0;
    endcase
  endfunction

  function automatic int out_stall_pct();
    case ((cmds_sent / 64) % 4)
      2: return 81;
      3: return 38;
      default: return 0;
    endcase
  endfunction

  task automatic rasterize_cmd(input op_t op, input logic [CB-1:0] x0, input logic [CB-1:0] y0,
                               input logic [CB-1:0] x1, input logic [CB-1:0] y1,
                               input logic [COLOR_BITS-1:0] c);
    pixel_write_t wr;
    int e2;
    if (op == OP_LOAD) begin
      ln_color = c;
      ln_busy = 1'b1;
      span_due = 1'b0;
      endpt_due = 1'b0;
      if (y0 == y1 || x0 == x1) begin
        span_due = 1'b1;
        cur_x = (x0 < x1) ? x0 : x1;
        cur_y = (y0 < y1) ? y0 : y1;
        span_w = ((x0 < x1) ? {1'b0, x1} : {1'b0, x0}) - {1'b0, cur_x} + 1'b1;
        span_h = ((y0 < y1) ? {1'b0, y1} : {1'b0, y0}) - {1'b0, cur_y} + 1'b1;
      end else begin
        endpt_due = 1'b1;
        cur_x = x0;
        cur_y = y0;
        dest_x = x1;
        dest_y = y1;
        neg_x = !(x0 < x1);
        neg_y = !(y0 < y1);
        dist_x = neg_x ? int'(x0) - int'(x1) : int'(x1) - int'(x0);
        dist_y = neg_y ? int'(y0) - int'(y1) : int'(y1) - int'(y0);
        err_acc = dist_x - dist_y;
      end
    end else if (ln_busy) begin
      wr.color = ln_color;
      wr.w = (CB+1)'(1);
      wr.h = (CB+1)'(1);
      wr.last = 1'b0;
      if (span_due) begin
        wr.x = cur_x;
        wr.y = cur_y;
        wr.w = span_w;
        wr.h = span_h;
        wr.last = 1'b1;
        span_due = 1'b0;
        ln_busy = 1'b0;
      end else if (endpt_due) begin
        wr.x = dest_x;
        wr.y = dest_y;
        endpt_due = 1'b0;
      end else begin
        wr.x = cur_x;
        wr.y = cur_y;
        e2 = err_acc * 2;
        if (e2 > -dist_y) begin
          err_acc -= dist_y;
          cur_x = neg_x ? cur_x - 1'b1 : cur_x + 1'b1;
        end
        if (e2 < dist_x) begin
          err_acc += dist_x;
          cur_y = neg_y ? cur_y - 1'b1 : cur_y + 1'b1;
        end
        wr.last = (cur_x == dest_x) && (cur_y == dest_y);
        if (wr.last) ln_busy = 1'b0;
      end
      expected_writes.push_back(wr);
    end
  endtask

  task automatic add_load(input int x0, input int y0, input int x1, input int y1, input int c);
    line_cmd_t cmd;
    cmd.op = OP_LOAD;
    cmd.sx = CB'(x0);
    cmd.sy = CB'(y0);
    cmd.ex = CB'(x1);
    cmd.ey = CB'(y1);
    cmd.color = COLOR_BITS'(c);
    line_cmds.push_back(cmd);
  endtask

  // step fields are ignored by the block, so fill them with noise
  task automatic add_steps(input int n);
    line_cmd_t cmd;
    for (int i = 0; i < n; i++) begin
      cmd.op = OP_STEP;
      cmd.sx = CB'($urandom);
      cmd.sy = CB'($urandom);
      cmd.ex = CB'($urandom);
      cmd.ey = CB'($urandom);
      cmd.color = COLOR_BITS'($urandom);
      line_cmds.push_back(cmd);
    end
  endtask

  function automatic int pick_end(input int s, input int span);
    int e;
    e = $urandom_range(0, 1) ? s + span : s - span;
    if (e > MAX_COORD) e = s - span;
    if (e < 0) e = s + span;
    if (e < 0 || e > MAX_COORD) e = (s + span) % (MAX_COORD + 1);
    return e;
  endfunction

  task automatic build_random_lines();
    int x0, y0, x1, y1, full, span;
    while (line_cmds.size() < RANDOM_ITEMS) begin
      if ($urandom_range(0, 99) < 8) begin
        add_steps($urandom_range(1, 3));
        continue;
      end
      x0 = $urandom_range(0, MAX_COORD);
      y0 = $urandom_range(0, MAX_COORD);
      if ($urandom_range(0, 99) < 20) begin
        case ($urandom_range(0, 2))
          0: begin x1 = $urandom_range(0, MAX_COORD); y1 = y0; end
          1: begin x1 = x0; y1 = $urandom_range(0, MAX_COORD); end
          default: begin x1 = x0; y1 = y0; end
        endcase
        full = 1;
      end else begin
        span = ($urandom_range(0, 99) < 5) ? $urandom_range(13, MAX_COORD) : $urandom_range(1, 12);
        x1 = pick_end(x0, span);
        span = ($urandom_range(0, 99) < 5) ? $urandom_range(13, MAX_COORD) : $urandom_range(1, 12);
        y1 = pick_end(y0, span);
        full = 1 + (((x1 > x0) ? x1 - x0 : x0 - x1) > ((y1 > y0) ? y1 - y0 : y0 - y1) ?
                    ((x1 > x0) ? x1 - x0 : x0 - x1) : ((y1 > y0) ? y1 - y0 : y0 - y1));
      end
      add_load(x0, y0, x1, y1, $urandom_range(0, 16'hFFFF));
      if (full > 60) begin
        add_steps($urandom_range(1, 40));
      end else begin
        case ($urandom_range(0, 19))
          0, 1, 2: add_steps($urandom_range(0, full - 1));
          3, 4: add_steps(full + $urandom_range(1, 3));
          default: add_steps(full);
        endcase
      end
    end
  endtask

  task automatic check_field(input string name, input logic [15:0] want, input logic [15:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
      mismatches++;
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        rasterize_cmd(op_t'(operation), start_x, start_y, end_x, end_y, pen_color);
      end
      if (!in_valid || !in_stall) begin
        if (line_cmds.size() != 0 && $urandom_range(0, 99) >= send_idle_pct()) begin
          next_cmd = line_cmds.pop_front();
          cmds_sent++;
          in_valid <= 1'b1;
          operation <= next_cmd.op;
          start_x <= next_cmd.sx;
          start_y <= next_cmd.sy;
          end_x <= next_cmd.ex;
          end_y <= next_cmd.ey;
          pen_color <= next_cmd.color;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      out_stall <= ($urandom_range(0, 99) < out_stall_pct());
      if (out_valid && !out_stall) begin
        got_write = '{pixel_x, pixel_y, run_width, run_height, out_color, last};
        if (expected_writes.size() == 0) begin
          $display("%0t: unexpected write x=%0d y=%0d w=%0d h=%0d color=%0h last=%0b",
                   $time, pixel_x, pixel_y, run_width, run_height, out_color, last);
          mismatches++;
        end else begin
          want_write = expected_writes.pop_front();
          check_field("pixel_x", 16'(want_write.x), 16'(got_write.x));
          check_field("pixel_y", 16'(want_write.y), 16'(got_write.y));
          check_field("run_width", 16'(want_write.w), 16'(got_write.w));
          check_field("run_height", 16'(want_write.h), 16'(got_write.h));
          check_field("out_color", want_write.color, got_write.color);
          check_field("last", 16'(want_write.last), 16'(got_write.last));
        end
      end
    end
  end

  always @(posedge clk) begin
    if (!rst) begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall) ||
          (line_cmds.size() == 0 && !in_valid && expected_writes.size() == 0)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles >= QUIET_LIMIT) begin
        $display("%0t: no transfer for %0d cycles", $time, QUIET_LIMIT);
        $display("Simulation FAILED");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  initial begin
    // step while idle, then full-width and full-height spans at the extremes
    add_steps(1);
    add_load(0, 0, MAX_COORD, 0, 16'hFFFF);
    add_steps(2);
    add_load(MAX_COORD, MAX_COORD, MAX_COORD, 0, 16'h0000);
    add_steps(1);
    // single point
    add_load(2048, 1000, 2048, 1000, 16'hA5A5);
    add_steps(1);
    // shallow and steep sloped lines walked to the end
    add_load(10, 10, 14, 12, 16'h1234);
    add_steps(5);
    add_load(20, 5, 18, 9, 16'h5A5A);
    add_steps(5);
    // drop a long diagonal midway with a new span
    add_load(MAX_COORD, 0, 0, MAX_COORD, 16'h8001);
    add_steps(3);
    add_load(100, 7, 3, 7, 16'h7FFE);
    add_steps(1);
    build_random_lines();

    repeat (6) @(posedge clk);
    rst <= 1'b0;

    while (line_cmds.size() != 0 || in_valid || expected_writes.size() != 0) begin
      @(negedge clk);
    end
    repeat (10) @(posedge clk);
    if (mismatches == 0 && expected_writes.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
